### hdl/dpdot_pkg.sv
// Shared types and codes for the diagonal prefix dot product unit.
package dpdot_pkg;

	localparam int SAMPLE_W = 16;
	localparam int SUM_W    = 48;
	localparam int IDX_W    = 7;
	localparam int LEN_W    = 8;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 48;

	typedef enum logic [1:0] {
		OP_WRITE_X = 2'd0,
		OP_WRITE_Y = 2'd1,
		OP_BUILD   = 2'd2,
		OP_QUERY   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_RANGE     = 2'd1,
		STATUS_NOT_BUILT = 2'd2
	} status_t;

	localparam logic REG_LENGTH_X = 1'b0;
	localparam logic REG_LENGTH_Y = 1'b1;

endpackage

### hdl/dpdot_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module dpdot_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### hdl/diagonal_prefix_dot_product_unit.sv
// Diagonal prefix dot product unit: sample stores, diagonal sum table, query path.
//
// Input stream (s_tvalid/s_tready, tuser = opcode, tdata = operands) carries
// sample writes, a table build command and window queries. Only queries give a
// result, on the output stream (tdata = window_sum, tuser = status).
// A transfer happens on a clock edge with tvalid and tready both high.
// A query reads the end entry of the window and the entry just before its start
// one after the other through the single read port of the table memory, then
// subtracts them into the output register.
// A build walks length_x * length_y table entries, one per cycle, through a
// three-stage read/multiply-add/write loop, then drains the loop before the table is marked built.
// The next input is taken while a finished result still waits in the output
// register; a query that completes while the output is stalled waits in its
// last state until the output register frees up.
// Reset (arst_n low) clears the control state and the built mark and sets both
// lengths to 128 (limited to MAX_LEN). Sample and table memories are not
// cleared. Writing a length register clears the built mark.
module diagonal_prefix_dot_product_unit
	import dpdot_pkg::*;
#(
	parameter int MAX_LEN = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [6:0] sample_index, [22:7] sample_value, [29:23] x_start,
	// [36:30] y_start, [44:37] window_length, [47:45] zero
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// [1:0] opcode
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [47:0] window_sum
	output logic [OUT_DATA_W-1:0] m_tdata,
	// [1:0] status
	output logic [1:0]            m_tuser,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [LEN_W-1:0]      cfg_data
);

	localparam int IW = $clog2(MAX_LEN);
	localparam int TW = 2 * IW;
	localparam int LEN_CAP = (MAX_LEN < 255) ? MAX_LEN : 255;
	localparam int LEN_RST = (MAX_LEN < 128) ? MAX_LEN : 128;
	localparam logic [LEN_W-1:0] LEN_CAP8 = LEN_W'(LEN_CAP);
	localparam logic [LEN_W-1:0] LEN_RST8 = LEN_W'(LEN_RST);

	typedef enum logic [2:0] {
		S_IDLE,
		S_BUILD,
		S_DRAIN,
		S_Q_END,
		S_Q_START
	} state_t;

	state_t state_q;

	// Input fields
	opcode_t                     in_op;
	logic [IDX_W-1:0]            in_idx;
	logic signed [SAMPLE_W-1:0]  in_val;
	logic [IDX_W-1:0]            in_xs;
	logic [IDX_W-1:0]            in_ys;
	logic [LEN_W-1:0]            in_len;

	assign in_op  = opcode_t'(s_tuser);
	assign in_idx = s_tdata[6:0];
	assign in_val = s_tdata[22:7];
	assign in_xs  = s_tdata[29:23];
	assign in_ys  = s_tdata[36:30];
	assign in_len = s_tdata[44:37];

	logic [LEN_W-1:0] len_x_q, len_y_q;
	logic             built_q;

	// Build loop
	logic [IW-1:0] bi_q, bj_q;
	logic          build_v_s1, build_v_s2;
	logic [IW-1:0] bi_s1, bj_s1;
	logic          first_s1;
	logic signed [SUM_W-1:0] prod_s2, prev_s2;
	logic [TW-1:0]           waddr_s2;

	// Query
	logic [TW-1:0]           qstart_addr_q;
	logic                    qsub_q;
	status_t                 qstatus_q;
	logic signed [SUM_W-1:0] qend_q;

	// Output register
	logic                    m_tvalid_q;
	logic [SUM_W-1:0]        m_sum_q;
	status_t                 m_status_q;

	logic accept, out_load, out_free, issue;
	logic bj_last, bi_last;

	// Memory ports
	logic                x_we, y_we;
	logic [IW-1:0]       smp_waddr;
	logic [SAMPLE_W-1:0] x_rdata, y_rdata;
	logic                t_re;
	logic [TW-1:0]       t_raddr;
	logic [SUM_W-1:0]    t_rdata;

	// Query decode
	logic [LEN_W:0]   xsum, ysum;
	logic [LEN_W:0]   xe9, ye9;
	logic             in_range, idx_ok;
	status_t          q_status;
	logic [TW-1:0]    qend_addr, qstart_addr;
	logic signed [SUM_W-1:0] qdiff;
	logic signed [2*SAMPLE_W-1:0] prod;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = (state_q == S_Q_START) && out_free;
	assign issue    = (state_q == S_BUILD);
	assign bj_last  = (bj_q == IW'(len_y_q - 8'd1));
	assign bi_last  = (bi_q == IW'(len_x_q - 8'd1));

	assign idx_ok    = (32'(in_idx) < MAX_LEN);
	assign smp_waddr = IW'(in_idx);
	assign x_we      = accept && (in_op == OP_WRITE_X) && idx_ok;
	assign y_we      = accept && (in_op == OP_WRITE_Y) && idx_ok;

	assign xsum = {2'b00, in_xs} + {1'b0, in_len};
	assign ysum = {2'b00, in_ys} + {1'b0, in_len};
	assign xe9  = xsum - 9'd1;
	assign ye9  = ysum - 9'd1;
	assign in_range = (in_len != '0) && (xsum <= {1'b0, len_x_q})
		&& (ysum <= {1'b0, len_y_q});

	always_comb begin
		if (!built_q) begin
			q_status = STATUS_NOT_BUILT;
		end else if (!in_range) begin
			q_status = STATUS_RANGE;
		end else begin
			q_status = STATUS_OK;
		end
	end

	assign qend_addr   = {IW'(xe9), IW'(ye9)};
	assign qstart_addr = {IW'(in_xs - 7'd1), IW'(in_ys - 7'd1)};

	// Table read port is shared: build issue, query end read, query start read.
	always_comb begin
		t_re    = 1'b0;
		t_raddr = qend_addr;
		case (state_q)
			S_IDLE: begin
				t_re    = accept && (in_op == OP_QUERY);
				t_raddr = qend_addr;
			end
			S_BUILD: begin
				t_re    = 1'b1;
				t_raddr = {bi_q - IW'(1), bj_q - IW'(1)};
			end
			S_Q_END: begin
				t_re    = 1'b1;
				t_raddr = qstart_addr_q;
			end
			default: begin
				t_re    = 1'b0;
				t_raddr = qstart_addr_q;
			end
		endcase
	end

	assign prod  = $signed(x_rdata) * $signed(y_rdata);
	assign qdiff = qend_q - (qsub_q ? $signed(t_rdata) : SUM_W'(0));

	dpdot_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_LEN)) u_x_ram (
		.clk     (clk),
		.wr_en   (x_we),
		.wr_addr (smp_waddr),
		.wr_data (in_val),
		.rd_en   (issue),
		.rd_addr (bi_q),
		.rd_data (x_rdata)
	);

	dpdot_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_LEN)) u_y_ram (
		.clk     (clk),
		.wr_en   (y_we),
		.wr_addr (smp_waddr),
		.wr_data (in_val),
		.rd_en   (issue),
		.rd_addr (bj_q),
		.rd_data (y_rdata)
	);

	// Entry (i-1,j-1) is read again when entry (i,j) is issued; for length_y >= 2 its write
	// has completed by then, so the read never overlaps a pending write.
	dpdot_ram #(.WIDTH(SUM_W), .DEPTH(1 << TW)) u_table_ram (
		.clk     (clk),
		.wr_en   (build_v_s2),
		.wr_addr (waddr_s2),
		.wr_data (prod_s2 + prev_s2),
		.rd_en   (t_re),
		.rd_addr (t_raddr),
		.rd_data (t_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			len_x_q    <= LEN_RST8;
			len_y_q    <= LEN_RST8;
			built_q    <= 1'b0;
			bi_q       <= '0;
			bj_q       <= '0;
			build_v_s1 <= 1'b0;
			build_v_s2 <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			build_v_s1 <= issue;
			build_v_s2 <= build_v_s1;

			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept && in_op == OP_BUILD) begin
						bi_q    <= '0;
						bj_q    <= '0;
						state_q <= S_BUILD;
					end else if (accept && in_op == OP_QUERY) begin
						state_q <= S_Q_END;
					end
				end
				S_BUILD: begin
					if (bj_last) begin
						bj_q <= '0;
						if (bi_last) begin
							state_q <= S_DRAIN;
						end else begin
							bi_q <= bi_q + IW'(1);
						end
					end else begin
						bj_q <= bj_q + IW'(1);
					end
				end
				S_DRAIN: begin
					if (!build_v_s1 && !build_v_s2) begin
						built_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_Q_END: begin
					state_q <= S_Q_START;
				end
				S_Q_START: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (cfg_we) begin
				built_q <= 1'b0;
				if (cfg_index == REG_LENGTH_X) begin
					if (cfg_data == '0) begin
						len_x_q <= LEN_W'(1);
					end else if (cfg_data > LEN_CAP8) begin
						len_x_q <= LEN_CAP8;
					end else begin
						len_x_q <= cfg_data;
					end
				end else if (cfg_index == REG_LENGTH_Y) begin
					if (cfg_data == '0) begin
						len_y_q <= LEN_W'(1);
					end else if (cfg_data > LEN_CAP8) begin
						len_y_q <= LEN_CAP8;
					end else begin
						len_y_q <= cfg_data;
					end
				end
			end
		end
	end

	// Datapath registers, no reset
	always_ff @(posedge clk) begin
		bi_s1    <= bi_q;
		bj_s1    <= bj_q;
		first_s1 <= (bi_q == '0) || (bj_q == '0);

		prod_s2  <= {{(SUM_W-2*SAMPLE_W){prod[2*SAMPLE_W-1]}}, prod};
		prev_s2  <= first_s1 ? SUM_W'(0) : $signed(t_rdata);
		waddr_s2 <= {bi_s1, bj_s1};

		if (accept && in_op == OP_QUERY) begin
			qstart_addr_q <= qstart_addr;
			qsub_q        <= (in_xs != '0) && (in_ys != '0);
			qstatus_q     <= q_status;
		end
		if (state_q == S_Q_END) begin
			qend_q <= $signed(t_rdata);
		end
		if (out_load) begin
			m_sum_q    <= (qstatus_q == STATUS_OK) ? qdiff : SUM_W'(0);
			m_status_q <= qstatus_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_sum_q;
	assign m_tuser  = m_status_q;

	a_no_accept_in_build: assert property (@(posedge clk) disable iff (!arst_n)
		(build_v_s1 || build_v_s2) |-> !s_tready)
		else $error("input accepted while build loop in flight");

	a_s2_follows_s1: assert property (@(posedge clk) disable iff (!arst_n)
		build_v_s2 |-> $past(build_v_s1))
		else $error("table write without a matching read stage");

	a_out_not_overwritten: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_tvalid || m_tready))
		else $error("output register loaded while holding an untaken result");

	a_built_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(built_q) |-> $past(state_q == S_DRAIN))
		else $error("table marked built outside build completion");

endmodule

### tb/diagonal_prefix_dot_product_unit_tb.sv
`timescale 1ns / 1ps
// Stream testbench for the diagonal prefix dot product unit with a predicting scoreboard.
module diagonal_prefix_dot_product_unit_tb;
	import dpdot_pkg::*;

	localparam int     DEPTH       = 128;
	localparam int     PHASES      = 14;
	localparam int     PHASE_ITEMS = 60;
	localparam int     HOLD_CYCLES = 400;
	localparam longint CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		status_t          status;
	} window_result_t;

	// Mirrors the sample stores, the diagonal table and the length registers.
	class dot_scoreboard;
		logic signed [SAMPLE_W-1:0] x_mem [DEPTH];
		logic signed [SAMPLE_W-1:0] y_mem [DEPTH];
		logic signed [SUM_W-1:0]    diag_sum [DEPTH*DEPTH];
		bit                         built;
		int unsigned                len_x;
		int unsigned                len_y;
		window_result_t             expected_q [$];
		int                         errors;

		function new();
			foreach (x_mem[i]) begin
				x_mem[i] = '0;
				y_mem[i] = '0;
			end
			built  = 1'b0;
			len_x  = DEPTH;
			len_y  = DEPTH;
			errors = 0;
		endfunction

		function void set_length(logic idx, logic [LEN_W-1:0] v);
			int unsigned c;
			c = (v == '0) ? 1 : ((32'(v) > DEPTH) ? DEPTH : 32'(v));
			if (idx == REG_LENGTH_X)
				len_x = c;
			else
				len_y = c;
			built = 1'b0;
		endfunction

		function void build_table();
			logic signed [SUM_W-1:0] p;
			for (int i = 0; i < len_x; i++) begin
				for (int j = 0; j < len_y; j++) begin
					p = x_mem[i] * y_mem[j];
					if (i > 0 && j > 0)
						p = p + diag_sum[(i-1)*DEPTH + j-1];
					diag_sum[i*DEPTH + j] = p;
				end
			end
			built = 1'b1;
		endfunction

		function void note_input(opcode_t op, logic [IN_DATA_W-1:0] d);
			int unsigned    xs, ys, wl;
			window_result_t r;
			case (op)
			OP_WRITE_X: x_mem[d[6:0]] = d[22:7];
			OP_WRITE_Y: y_mem[d[6:0]] = d[22:7];
			OP_BUILD:   build_table();
			OP_QUERY: begin
				xs    = 32'(d[29:23]);
				ys    = 32'(d[36:30]);
				wl    = 32'(d[44:37]);
				r.sum = '0;
				if (!built) begin
					r.status = STATUS_NOT_BUILT;
				end else if (wl == 0 || xs + wl > len_x || ys + wl > len_y) begin
					r.status = STATUS_RANGE;
				end else begin
					r.status = STATUS_OK;
					r.sum    = diag_sum[(xs+wl-1)*DEPTH + ys+wl-1];
					// window not touching row 0 or column 0: remove the diagonal prefix
					if (xs > 0 && ys > 0)
						r.sum = r.sum - diag_sum[(xs-1)*DEPTH + ys-1];
				end
				expected_q.push_back(r);
			end
			default: ;
			endcase
		endfunction

		function void check_result(logic [SUM_W-1:0] sum, logic [1:0] st);
			window_result_t e;
			if (expected_q.size() == 0) begin
				$error("unexpected result transfer: window_sum %0d, status %0d", $signed(sum), st);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (sum !== e.sum) begin
				$error("window_sum mismatch: expected %0d, got %0d", $signed(e.sum), $signed(sum));
				errors++;
			end
			if (st !== e.status) begin
				$error("status mismatch: expected %0d, got %0d", e.status, st);
				errors++;
			end
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	wire                   s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic [1:0]            s_tuser   = '0;
	wire                   m_tvalid;
	logic                  m_tready  = 1'b0;
	wire  [OUT_DATA_W-1:0] m_tdata;
	wire  [1:0]            m_tuser;
	logic                  cfg_we    = 1'b0;
	logic                  cfg_index = 1'b0;
	logic [LEN_W-1:0]      cfg_data  = '0;

	dot_scoreboard sb = new();
	bit            x_written [DEPTH];
	bit            y_written [DEPTH];
	int            send_idle_pct  = 0;
	int            recv_stall_pct = 0;
	bit            hold_req       = 1'b0;
	longint        cycles         = 0;

	diagonal_prefix_dot_product_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
		if (arst_n && s_tvalid && s_tready)
			sb.note_input(opcode_t'(s_tuser), s_tdata);
	end

	// Output side: random stalls, plus a long hold-off on request.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// tdata layout from bit 0: sample_index, sample_value, x_start, y_start, window_length
	function automatic logic [IN_DATA_W-1:0] pack_item(logic [IDX_W-1:0] idx,
			logic [SAMPLE_W-1:0] val, logic [IDX_W-1:0] xs, logic [IDX_W-1:0] ys,
			logic [LEN_W-1:0] wl);
		return {3'b000, wl, ys, xs, val, idx};
	endfunction

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(9))
		0:       return 16'h8000;
		1:       return 16'h7fff;
		default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic [IDX_W-1:0] pick_index(int unsigned len);
		return IDX_W'(($urandom_range(4) == 0) ? $urandom_range(DEPTH-1)
			: $urandom_range(len-1));
	endfunction

	task automatic send_item(opcode_t op, logic [IN_DATA_W-1:0] d);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic write_sample(opcode_t op, logic [IDX_W-1:0] idx, logic [SAMPLE_W-1:0] v);
		send_item(op, pack_item(idx, v, IDX_W'($urandom), IDX_W'($urandom),
			LEN_W'($urandom)));
		if (op == OP_WRITE_X)
			x_written[idx] = 1'b1;
		else
			y_written[idx] = 1'b1;
	endtask

	task automatic query_item(logic [IDX_W-1:0] xs, logic [IDX_W-1:0] ys, logic [LEN_W-1:0] wl);
		send_item(OP_QUERY, pack_item(IDX_W'($urandom), SAMPLE_W'($urandom), xs, ys, wl));
	endtask

	// a build must never read a sample that was never written
	task automatic build_item();
		for (int i = 0; i < sb.len_x; i++)
			if (!x_written[i]) write_sample(OP_WRITE_X, IDX_W'(i), rand_sample());
		for (int i = 0; i < sb.len_y; i++)
			if (!y_written[i]) write_sample(OP_WRITE_Y, IDX_W'(i), rand_sample());
		send_item(OP_BUILD, pack_item(IDX_W'($urandom), SAMPLE_W'($urandom),
			IDX_W'($urandom), IDX_W'($urandom), LEN_W'($urandom)));
	endtask

	task automatic await_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.expected_q.size() > 0);
	endtask

	// drain, then give a trailing build time to finish
	task automatic settle();
		await_results();
		repeat (sb.len_x * sb.len_y + 16) @(posedge clk);
	endtask

	task automatic program_lengths(logic [LEN_W-1:0] lx, logic [LEN_W-1:0] ly);
		cfg_we    <= 1'b1;
		cfg_index <= REG_LENGTH_X;
		cfg_data  <= lx;
		@(posedge clk);
		sb.set_length(REG_LENGTH_X, lx);
		cfg_index <= REG_LENGTH_Y;
		cfg_data  <= ly;
		@(posedge clk);
		sb.set_length(REG_LENGTH_Y, ly);
		cfg_we    <= 1'b0;
	endtask

	task automatic random_phase(int n_items, int pause_at);
		int unsigned lx, ly;
		int          sel, build_pct, wl;
		lx = sb.len_x;
		ly = sb.len_y;
		for (int k = 0; k < n_items; k++) begin
			if (k == pause_at)
				await_results();
			if (!sb.built)
				build_pct = 20;
			else if (lx * ly > 4096)
				build_pct = 0;
			else
				build_pct = 5;
			sel = $urandom_range(99);
			if (sel < 15) begin
				write_sample(OP_WRITE_X, pick_index(lx), rand_sample());
			end else if (sel < 30) begin
				write_sample(OP_WRITE_Y, pick_index(ly), rand_sample());
			end else if (sel < 30 + build_pct) begin
				build_item();
			end else if ($urandom_range(3) != 0) begin
				wl = $urandom_range(1, (lx < ly) ? lx : ly);
				query_item(IDX_W'($urandom_range(0, lx - wl)),
					IDX_W'($urandom_range(0, ly - wl)), LEN_W'(wl));
			end else begin
				query_item(IDX_W'($urandom), IDX_W'($urandom), LEN_W'($urandom));
			end
		end
	endtask

	initial begin : stimulus
		logic [LEN_W-1:0] lx, ly;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: not-built, extremes, range errors, stale table
		query_item(0, 0, 1);
		settle();
		program_lengths(8'd4, 8'd5);
		write_sample(OP_WRITE_X, 0, 16'h7fff);
		write_sample(OP_WRITE_X, 1, 16'h8000);
		write_sample(OP_WRITE_X, 2, 16'h0001);
		write_sample(OP_WRITE_X, 3, 16'hffff);
		write_sample(OP_WRITE_X, 127, 16'h5a5a);
		write_sample(OP_WRITE_Y, 0, 16'h8000);
		write_sample(OP_WRITE_Y, 1, 16'h8000);
		write_sample(OP_WRITE_Y, 2, 16'h7fff);
		write_sample(OP_WRITE_Y, 3, 16'h0000);
		write_sample(OP_WRITE_Y, 4, 16'h3039);
		query_item(0, 0, 1);
		build_item();
		query_item(0, 0, 4);
		query_item(1, 2, 3);
		query_item(3, 0, 1);
		query_item(0, 0, 0);
		query_item(2, 0, 3);
		query_item(0, 3, 3);
		query_item(127, 127, 255);
		write_sample(OP_WRITE_X, 1, 16'h0064);
		query_item(1, 1, 2);
		build_item();
		query_item(1, 1, 2);

		for (int p = 1; p < PHASES; p++) begin
			settle();
			case (p)
			1:       begin lx = 8'd0;   ly = 8'd255; end
			2:       begin lx = 8'd255; ly = 8'd0;   end
			3:       begin lx = 8'd128; ly = 8'd128; end
			4:       begin lx = 8'd1;   ly = 8'd1;   end
			5:       begin lx = 8'd129; ly = 8'd2;   end
			default: begin
				lx = LEN_W'($urandom_range(2, 24));
				ly = LEN_W'($urandom_range(2, 24));
			end
			endcase
			program_lengths(lx, ly);
			case (p % 4)
			0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1:       begin send_idle_pct = 88; recv_stall_pct = 0;  end
			2:       begin send_idle_pct = 0;  recv_stall_pct = 88; end
			default: begin send_idle_pct = 32; recv_stall_pct = 32; end
			endcase
			if (p == 8)
				hold_req = 1'b1;
			random_phase(PHASE_ITEMS, (p == 6) ? PHASE_ITEMS / 2 : -1);
		end

		settle();
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
